### hdl/sbl_pkg.sv
package sbl_pkg;

	localparam int DATA_W    = 24;
	localparam int PCT_W     = 7;
	localparam int BAND_W    = 4;
	localparam int ROW_W     = 4;
	localparam int STRIP_W   = 8;
	localparam int COLOR_W   = 8;
	localparam int MAX_HGT_W = 6;

	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	// floor(x / 100) = (x * RECIP100) >> RECIP100_SHIFT for any x below 2^31
	localparam logic [31:0] RECIP100       = 32'd2748779070;
	localparam int          RECIP100_SHIFT = 38;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_FLOOR  = 1'b1;

	typedef enum logic [2:0] {
		REG_RISE   = 3'd0,
		REG_FALL   = 3'd1,
		REG_MINCHG = 3'd2,
		REG_FLRMIN = 3'd3,
		REG_SPAN   = 3'd4,
		REG_BRIGHT = 3'd5
	} reg_idx_t;

	localparam logic [PCT_W-1:0]  RST_RISE   = 7'd60;
	localparam logic [PCT_W-1:0]  RST_FALL   = 7'd20;
	localparam logic [DATA_W-1:0] RST_MINCHG = 24'd0;
	localparam logic [DATA_W-1:0] RST_FLRMIN = 24'd256;
	localparam logic [DATA_W-1:0] RST_SPAN   = 24'd65536;
	localparam logic [PCT_W-1:0]  RST_BRIGHT = 7'd50;

	typedef struct packed {
		logic              op;
		logic [BAND_W-1:0] band;
		logic [DATA_W-1:0] magnitude;
	} item_t;

	typedef struct packed {
		logic [BAND_W-1:0]  pixel_column;
		logic [ROW_W-1:0]   pixel_row;
		logic [STRIP_W-1:0] strip_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last;
	} pixel_t;

	typedef struct packed {
		logic [PCT_W-1:0]  rise_percent;
		logic [PCT_W-1:0]  fall_percent;
		logic [DATA_W-1:0] min_change;
		logic [DATA_W-1:0] floor_minimum;
		logic [DATA_W-1:0] level_span;
		logic [PCT_W-1:0]  brightness_percent;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [BAND_W-1:0]    column;
		logic [MAX_HGT_W-1:0] height;
	} draw_t;

	function automatic logic [PCT_W-1:0] sat100(input logic [PCT_W-1:0] p);
		return (p > 7'd100) ? 7'd100 : p;
	endfunction

endpackage

### hdl/sbl_ram.sv
module sbl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/sbl_front.sv
module sbl_front #(
	parameter int BANDS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sbl_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic           pop,
	output sbl_pkg::item_t head,
	output logic           head_valid
);

	sbl_pkg::item_t                 q_mem_q [sbl_pkg::QDEPTH];
	logic [sbl_pkg::QPW-1:0]        wr_q;
	logic [sbl_pkg::QPW-1:0]        rd_q;
	logic [sbl_pkg::QPW:0]          cnt_q;
	logic                           accept;
	logic                           in_range;
	logic                           push;

	assign item_stall = (cnt_q == (sbl_pkg::QPW + 1)'(sbl_pkg::QDEPTH));
	assign accept     = item_valid && !item_stall;
	// bands past the last column are dropped here and never queued
	assign in_range   = (32'(item.band) < BANDS);
	assign push       = accept && in_range;
	assign head       = q_mem_q[rd_q];
	assign head_valid = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_q] <= item;
		end
	end

endmodule

### hdl/sbl_back.sv
module sbl_back #(
	parameter int BANDS  = 16,
	parameter int HEIGHT = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sbl_pkg::cfg_t  cfg,
	input  sbl_pkg::item_t head,
	input  logic           head_valid,
	output logic           pop,
	output sbl_pkg::draw_t draw,
	input  logic           draw_ready
);

	localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int RW = $clog2(HEIGHT);
	localparam int NW = sbl_pkg::DATA_W + RW + 2;
	localparam int CW = $clog2(RW + 1);
	localparam int DW = sbl_pkg::DATA_W;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL    = 8'b0000_0010,
		ST_RECIP  = 8'b0000_0100,
		ST_UPDATE = 8'b0000_1000,
		ST_DIFF   = 8'b0001_0000,
		ST_NUM    = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_DRAW   = 8'b1000_0000
	} state_t;

	state_t                  state_q;
	state_t                  nxt;
	sbl_pkg::item_t          item_q;
	logic [AW-1:0]           raddr;
	logic [AW-1:0]           addr_q;
	logic [BANDS-1:0]        lvl_vld_q;
	logic [BANDS-1:0]        flr_vld_q;
	logic                    lvl_rv_q;
	logic                    flr_rv_q;
	logic [DW-1:0]           lvl_rd;
	logic [DW-1:0]           flr_rd;
	logic                    flr_we;
	logic                    lvl_we;
	logic [DW-1:0]           old_lvl;
	logic [DW-1:0]           old_flr;
	logic                    rising;
	logic [DW-1:0]           dlt;
	logic [sbl_pkg::PCT_W-1:0] pct;
	logic [DW-1:0]           old_q;
	logic                    rising_q;
	logic                    hold_q;
	logic [30:0]             prod_q;
	logic [DW-1:0]           floor_q;
	logic [62:0]             rprod;
	logic [DW-1:0]           step_q;
	logic [DW-1:0]           new_lvl;
	logic [DW-1:0]           level_q;
	logic                    above_q;
	logic [DW-1:0]           diff_q;
	logic [DW-1:0]           span;
	logic                    short_cut;
	logic [NW-1:0]           num_q;
	logic [NW-1:0]           dsh_q;
	logic                    ge;
	logic [RW-1:0]           quo_q;
	logic [CW-1:0]           cnt_q;

	assign raddr  = AW'(head.band);
	assign addr_q = AW'(item_q.band);
	assign pop    = (state_q == ST_IDLE) && head_valid;
	assign flr_we = pop && (head.op == sbl_pkg::OP_FLOOR);
	assign lvl_we = (state_q == ST_UPDATE);

	sbl_ram #(.WIDTH(DW), .DEPTH(BANDS)) u_level (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (addr_q),
		.wdata (new_lvl),
		.raddr (raddr),
		.rdata (lvl_rd)
	);

	sbl_ram #(.WIDTH(DW), .DEPTH(BANDS)) u_floor (
		.clk   (clk),
		.we    (flr_we),
		.waddr (raddr),
		.wdata (head.magnitude),
		.raddr (raddr),
		.rdata (flr_rd)
	);

	// never-written entries read as zero
	assign old_lvl = lvl_rv_q ? lvl_rd : '0;
	assign old_flr = flr_rv_q ? flr_rd : '0;
	assign rising  = (item_q.magnitude > old_lvl);
	assign dlt     = rising ? (item_q.magnitude - old_lvl) : (old_lvl - item_q.magnitude);
	assign pct     = rising ? sbl_pkg::sat100(cfg.rise_percent)
	                        : sbl_pkg::sat100(cfg.fall_percent);

	assign rprod   = {32'd0, prod_q} * {31'd0, sbl_pkg::RECIP100};

	always_comb begin
		if (hold_q) begin
			new_lvl = old_q;
		end else if (rising_q) begin
			new_lvl = old_q + step_q;
		end else begin
			new_lvl = old_q - step_q;
		end
	end

	assign span      = (cfg.level_span == '0) ? DW'(1) : cfg.level_span;
	assign short_cut = !above_q || (diff_q >= span);
	assign ge        = (num_q >= dsh_q);

	always_comb begin
		nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && (head.op == sbl_pkg::OP_UPDATE)) begin
					nxt = ST_MUL;
				end
			end
			ST_MUL:    nxt = ST_RECIP;
			ST_RECIP:  nxt = ST_UPDATE;
			ST_UPDATE: nxt = ST_DIFF;
			ST_DIFF:   nxt = ST_NUM;
			ST_NUM:    nxt = short_cut ? ST_DRAW : ST_DIV;
			ST_DIV: begin
				if (cnt_q == CW'(RW - 1)) begin
					nxt = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (draw_ready) begin
					nxt = ST_IDLE;
				end
			end
			default:   nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lvl_vld_q <= '0;
			flr_vld_q <= '0;
		end else begin
			state_q <= nxt;
			if (flr_we) begin
				flr_vld_q[raddr] <= 1'b1;
			end
			if (lvl_we) begin
				lvl_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		lvl_rv_q <= lvl_vld_q[raddr];
		flr_rv_q <= flr_vld_q[raddr];
		if (pop) begin
			item_q <= head;
		end
		if (state_q == ST_MUL) begin
			old_q    <= old_lvl;
			rising_q <= rising;
			hold_q   <= (dlt < cfg.min_change);
			prod_q   <= {24'd0, pct} * {7'd0, dlt};
			floor_q  <= (old_flr > cfg.floor_minimum) ? old_flr : cfg.floor_minimum;
		end
		if (state_q == ST_RECIP) begin
			step_q <= rprod[sbl_pkg::RECIP100_SHIFT +: DW];
		end
		if (state_q == ST_UPDATE) begin
			level_q <= new_lvl;
		end
		if (state_q == ST_DIFF) begin
			above_q <= (level_q > floor_q);
			diff_q  <= level_q - floor_q;
		end
		if (state_q == ST_NUM) begin
			// a difference of a full span or more always rounds to the top row
			quo_q <= (above_q && short_cut) ? RW'(HEIGHT - 1) : '0;
			num_q <= ((NW'(diff_q) * NW'(HEIGHT - 1)) << 1) + NW'(span);
			dsh_q <= NW'(span) << RW;
			cnt_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (ge) begin
				num_q <= num_q - dsh_q;
			end
			quo_q <= (quo_q << 1) | RW'(ge);
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		draw.valid  = (state_q == ST_DRAW);
		draw.column = item_q.band;
		draw.height = sbl_pkg::MAX_HGT_W'(quo_q);
	end

endmodule

### hdl/sbl_pixel.sv
module sbl_pixel #(
	parameter int HEIGHT = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sbl_pkg::PCT_W-1:0]   brightness,
	input  sbl_pkg::draw_t              draw,
	output logic                        draw_ready,
	output sbl_pkg::pixel_t             pixel,
	output logic                        pixel_valid,
	input  logic                        pixel_stall
);

	localparam int RW = $clog2(HEIGHT);
	localparam int PW = RW + sbl_pkg::PCT_W;
	localparam int K  = 34;
	localparam int MW = 36;
	localparam logic [63:0] DEN    = 64'(100 * (HEIGHT - 1));
	localparam logic [63:0] RECIP  = ((64'd1 << K) + DEN - 64'd1) / DEN;
	localparam logic [MW-1:0] MUL_RG = MW'(RECIP * 64'd255);
	localparam logic [MW-1:0] MUL_B  = MW'(RECIP * 64'd160);
	localparam logic [RW-1:0] TOP    = RW'(HEIGHT - 1);

	logic                           busy_q;
	logic [RW-1:0]                  row_q;
	logic [RW-1:0]                  hgt_q;
	logic [sbl_pkg::BAND_W-1:0]     col_q;
	logic                           en;
	logic                           take;
	logic                           iss;
	logic                           iss_last;
	logic [sbl_pkg::PCT_W-1:0]      bri;
	logic [RW:0]                    twoy;
	logic [RW:0]                    gw;

	logic                           vld_s1;
	logic [RW-1:0]                  row_s1;
	logic [sbl_pkg::BAND_W-1:0]     col_s1;
	logic                           last_s1;
	logic [PW-1:0]                  yb_s1;
	logic [PW-1:0]                  gb_s1;
	logic [PW-1:0]                  bb_s1;

	logic [PW+MW-1:0]               rp;
	logic [PW+MW-1:0]               gp;
	logic [PW+MW-1:0]               bp;

	logic                           vld_s2;
	logic [RW-1:0]                  row_s2;
	logic [sbl_pkg::BAND_W-1:0]     col_s2;
	logic                           last_s2;
	logic [sbl_pkg::COLOR_W-1:0]    red_s2;
	logic [sbl_pkg::COLOR_W-1:0]    green_s2;
	logic [sbl_pkg::COLOR_W-1:0]    blue_s2;

	logic                           pixel_valid_q;
	sbl_pkg::pixel_t                pixel_q;

	// whole pipe freezes while a finished pixel waits at the output
	assign en         = !(pixel_valid_q && pixel_stall);
	assign draw_ready = !busy_q;
	assign take       = draw.valid && !busy_q;
	assign iss        = busy_q && en;
	assign iss_last   = (row_q == hgt_q);
	assign bri        = sbl_pkg::sat100(brightness);

	// green ramp is top - |2y - top|, which folds to 2y or 2(top - y)
	assign twoy = {row_q, 1'b0};
	assign gw   = (twoy > (RW + 1)'(TOP)) ? {TOP - row_q, 1'b0} : twoy;

	assign rp = (PW + MW)'(yb_s1) * (PW + MW)'(MUL_RG);
	assign gp = (PW + MW)'(gb_s1) * (PW + MW)'(MUL_RG);
	assign bp = (PW + MW)'(bb_s1) * (PW + MW)'(MUL_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			pixel_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (iss && iss_last) begin
				busy_q <= 1'b0;
			end
			if (en) begin
				vld_s1        <= iss;
				vld_s2        <= vld_s1;
				pixel_valid_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_q <= '0;
			hgt_q <= RW'(draw.height);
			col_q <= draw.column;
		end else if (iss && !iss_last) begin
			row_q <= row_q + 1'b1;
		end
		if (en) begin
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= iss_last;
			yb_s1   <= PW'(row_q) * PW'(bri);
			gb_s1   <= PW'(RW'(gw)) * PW'(bri);
			bb_s1   <= PW'(TOP - row_q) * PW'(bri);

			row_s2   <= row_s1;
			col_s2   <= col_s1;
			last_s2  <= last_s1;
			red_s2   <= rp[K +: sbl_pkg::COLOR_W];
			green_s2 <= gp[K +: sbl_pkg::COLOR_W];
			blue_s2  <= bp[K +: sbl_pkg::COLOR_W];

			pixel_q.pixel_column <= col_s2;
			pixel_q.pixel_row    <= sbl_pkg::ROW_W'(row_s2);
			pixel_q.strip_index  <= sbl_pkg::STRIP_W'(
				8'({4'd0, col_s2}) * 8'(HEIGHT) + 8'(row_s2));
			pixel_q.red          <= red_s2;
			pixel_q.green        <= green_s2;
			pixel_q.blue         <= blue_s2;
			pixel_q.last         <= last_s2;
		end
	end

	assign pixel       = pixel_q;
	assign pixel_valid = pixel_valid_q;

endmodule

### hdl/spectrum_bar_level_renderer.sv
// throughput: one pixel per cycle while pixel_stall is low; a bar of height h streams as h+1
// pixels while the level sequencer works the next item
// a floor write retires from the queue as it is popped, without leaving the idle state
// reset: configuration registers return to their defaults, level and floor stores read as zero
// through per-band valid bits cleared at once, so no clearing pass is needed
module spectrum_bar_level_renderer #(
	parameter int BANDS  = 16,
	parameter int HEIGHT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sbl_pkg::item_t  item,
	input  logic            item_valid,
	output logic            item_stall,
	output sbl_pkg::pixel_t pixel,
	output logic            pixel_valid,
	input  logic            pixel_stall,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [4:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	sbl_pkg::cfg_t  cfg_q;
	sbl_pkg::item_t head;
	logic           head_valid;
	logic           pop;
	sbl_pkg::draw_t draw;
	logic           draw_ready;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_percent       <= sbl_pkg::RST_RISE;
			cfg_q.fall_percent       <= sbl_pkg::RST_FALL;
			cfg_q.min_change         <= sbl_pkg::RST_MINCHG;
			cfg_q.floor_minimum      <= sbl_pkg::RST_FLRMIN;
			cfg_q.level_span         <= sbl_pkg::RST_SPAN;
			cfg_q.brightness_percent <= sbl_pkg::RST_BRIGHT;
		end else if (cfg_wr) begin
			case (sbl_pkg::reg_idx_t'(paddr[4:2]))
				sbl_pkg::REG_RISE:   cfg_q.rise_percent       <= pwdata[6:0];
				sbl_pkg::REG_FALL:   cfg_q.fall_percent       <= pwdata[6:0];
				sbl_pkg::REG_MINCHG: cfg_q.min_change         <= pwdata[23:0];
				sbl_pkg::REG_FLRMIN: cfg_q.floor_minimum      <= pwdata[23:0];
				sbl_pkg::REG_SPAN:   cfg_q.level_span         <= pwdata[23:0];
				sbl_pkg::REG_BRIGHT: cfg_q.brightness_percent <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sbl_pkg::reg_idx_t'(paddr[4:2]))
			sbl_pkg::REG_RISE:   prdata = 32'(cfg_q.rise_percent);
			sbl_pkg::REG_FALL:   prdata = 32'(cfg_q.fall_percent);
			sbl_pkg::REG_MINCHG: prdata = 32'(cfg_q.min_change);
			sbl_pkg::REG_FLRMIN: prdata = 32'(cfg_q.floor_minimum);
			sbl_pkg::REG_SPAN:   prdata = 32'(cfg_q.level_span);
			sbl_pkg::REG_BRIGHT: prdata = 32'(cfg_q.brightness_percent);
			default:             prdata = '0;
		endcase
	end

	sbl_front #(.BANDS(BANDS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	sbl_back #(.BANDS(BANDS), .HEIGHT(HEIGHT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.draw       (draw),
		.draw_ready (draw_ready)
	);

	sbl_pixel #(.HEIGHT(HEIGHT)) u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.brightness  (cfg_q.brightness_percent),
		.draw        (draw),
		.draw_ready  (draw_ready),
		.pixel       (pixel),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall)
	);

	a_draw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(draw.valid && !draw_ready) |=> (draw.valid && $stable(draw)))
		else $error("bar request changed before the pixel unit took it");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_bar_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel.last) |=> pixel_valid)
		else $error("gap inside a bar");

	a_height_max: assert property (@(posedge clk) disable iff (!arst_n)
		draw.valid |-> (draw.height <= sbl_pkg::MAX_HGT_W'(HEIGHT - 1)))
		else $error("bar height above the top row");

endmodule
